[rtl/mersenne_twister_generator_top_defines.svh]
// Assertion macros shared by the generator RTL.
// Depends on nothing; include by bare file name.
`ifndef MERSENNE_TWISTER_GENERATOR_TOP_DEFINES_SVH
`define MERSENNE_TWISTER_GENERATOR_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define MTG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define MTG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/mtg_pkg.sv]
// Package: constants, item kinds and shared types of the MT19937 generator.
// No dependencies.
package mtg_pkg;
  localparam int STATE_WORDS  = 624;
  localparam int SHIFT_OFFSET = 397;
  localparam int IDX_W        = 10;
  localparam logic [31:0] TWIST_XOR     = 32'h9908b0df;
  localparam logic [31:0] HIGH_BIT      = 32'h80000000;
  localparam logic [31:0] LOW_BITS      = 32'h7fffffff;
  localparam logic [31:0] INIT_MULT     = 32'd1812433253;
  localparam logic [31:0] SEED_AT_RESET = 32'd5489;
  localparam logic [31:0] TEMPER_B      = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C      = 32'hefc60000;

  typedef enum logic [1:0] {
    KIND_RAW = 2'd0, KIND_BOUNDED = 2'd1, KIND_RESTART = 2'd2, KIND_NONE = 2'd3
  } kind_t;

  // queued command from front to back
  typedef struct packed {
    kind_t       kind;
    logic [31:0] limit;
    logic [31:0] mask;
  } cmd_t;

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic logic [31:0] smear(input logic [31:0] x);
    logic [31:0] m;
    m = x;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    m = m | (m >> 16);
    return m;
  endfunction
endpackage

[rtl/mtg_if.sv]
// Valid/ready channel interfaces for the generator.
// Depends on mtg_pkg.
interface mtg_in_if;
  logic              valid;
  logic              ready;
  mtg_pkg::kind_t    kind;
  logic [31:0]       limit;
  modport source (output valid, kind, limit, input ready);
  modport sink (input valid, kind, limit, output ready);
endinterface

interface mtg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  modport source (output valid, value, input ready);
  modport sink (input valid, value, output ready);
endinterface

interface mtg_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[rtl/mtg_ram.sv]
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module mtg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

[rtl/mtg_front.sv]
// Front end: accepts items, drops unused kinds, computes the bound mask,
// and holds a two-entry command queue. Depends on mtg_pkg and mtg_if.
module mtg_front (
  input  logic          clk,
  input  logic          rst_n,
  mtg_in_if.sink        in_ch,
  output mtg_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_pop
);
  import mtg_pkg::*;

  cmd_t       q_r [2];
  logic [1:0] cnt_r;
  logic       rd_r;
  logic       wr_r;
  logic       push;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready && (in_ch.kind != KIND_NONE);
  assign cmd = q_r[rd_r];
  assign cmd_valid = (cnt_r != 2'd0);

  // store entry and advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      if (push) begin
        q_r[wr_r] <= '{kind: in_ch.kind, limit: in_ch.limit, mask: smear(in_ch.limit)};
        wr_r <= ~wr_r;
      end
      if (cmd_pop) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, cmd_pop};
    end
  end
endmodule

[rtl/mtg_back.sv]
// Back end: seeds, twists and reads the state table, tempers and bounds.
// Depends on mtg_pkg, mtg_if, mtg_ram and the defines header.
`include "mersenne_twister_generator_top_defines.svh"
module mtg_back (
  input  logic          clk,
  input  logic          rst_n,
  input  mtg_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_pop,
  mtg_cfg_if.sink       cfg_ch,
  mtg_out_if.source     out_ch
);
  import mtg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SEED_MUL, S_SEED_WR, S_TW_PRE, S_TW_RD, S_TW_WR, S_DRAW_CHK
  } state_t;

  state_t            state_r;
  logic [IDX_W-1:0]  ridx_r;    // next word to read
  logic              seeded_r;
  logic              twisted_r;  // table holds fresh twisted words
  logic [IDX_W-1:0]  k_r;
  logic [31:0]       seed_r;
  logic [31:0]       prod_r;
  logic [31:0]       y0_r;      // current table[k] for the twist step
  logic              y0_ok_r;
  logic [31:0]       out_r;
  logic              ov_r;
  logic              dpop_r;   // command belongs to a seed-then-draw path

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [31:0]       wdata;
  logic [IDX_W-1:0]  ra, rb;
  logic [31:0]       da, db;
  logic [IDX_W-1:0]  k_next, k_far;
  logic [31:0]       y, tw, tv, bv;

  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ov_r;
  assign out_ch.value = out_r;

  mtg_ram #(.WIDTH(32), .DEPTH(STATE_WORDS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(ra), .rdata_a(da), .raddr_b(rb), .rdata_b(db)
  );

  // twist neighbor indexes
  always_comb begin
    k_next = (k_r == IDX_W'(STATE_WORDS - 1)) ? '0 : k_r + 1'b1;
    k_far  = (k_r >= IDX_W'(STATE_WORDS - SHIFT_OFFSET))
           ? k_r - IDX_W'(STATE_WORDS - SHIFT_OFFSET)
           : k_r + IDX_W'(SHIFT_OFFSET);
  end

  // read addresses: twist reads next and far, prefetch reads word 0,
  // draw reads the index
  always_comb begin
    ra = k_next;
    rb = k_far;
    if (state_r == S_IDLE) begin
      ra = ridx_r;
    end else if (state_r == S_TW_PRE) begin
      ra = k_r;
    end
  end

  assign y  = ((y0_ok_r ? y0_r : 32'd0) & HIGH_BIT) | (da & LOW_BITS);
  assign tw = db ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 32'd0);
  assign tv = temper(da);
  assign bv = tv & cmd.mask;

  // table write port
  always_comb begin
    we    = 1'b0;
    waddr = k_r;
    wdata = prod_r + {22'd0, k_r};
    unique case (state_r)
      S_SEED_WR: we = 1'b1;
      S_TW_WR:   begin we = 1'b1; wdata = tw; end
      default:   we = 1'b0;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ridx_r    <= '0;
      seeded_r  <= 1'b0;
      twisted_r <= 1'b0;
      seed_r    <= SEED_AT_RESET;
      ov_r      <= 1'b0;
      cmd_pop   <= 1'b0;
      dpop_r    <= 1'b0;
      y0_ok_r   <= 1'b0;
    end else begin
      cmd_pop <= 1'b0;
      if (cfg_ch.valid) begin
        seed_r <= cfg_ch.data;
      end
      if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid && !cmd_pop) begin
            if (cmd.kind == KIND_RESTART || !seeded_r) begin
              // write seed word 0 then run the multiply chain
              prod_r <= seed_r;
              k_r    <= '0;
              dpop_r <= (cmd.kind != KIND_RESTART);
              state_r <= S_SEED_WR;
            end else if (!(ov_r && !out_ch.ready)) begin
              if (!twisted_r || ridx_r == IDX_W'(STATE_WORDS)) begin
                k_r <= '0;
                y0_ok_r <= 1'b0;
                state_r <= S_TW_PRE;
              end else begin
                state_r <= S_DRAW_CHK;
              end
            end
          end
        end
        S_SEED_WR: begin
          if (k_r == IDX_W'(STATE_WORDS - 1)) begin
            seeded_r  <= 1'b1;
            twisted_r <= 1'b0;
            ridx_r    <= IDX_W'(STATE_WORDS);
            if (!dpop_r) begin
              cmd_pop <= 1'b1;
            end
            state_r <= S_IDLE;
          end else begin
            k_r <= k_r + 1'b1;
            state_r <= S_SEED_MUL;
          end
        end
        S_SEED_MUL: begin
          prod_r <= INIT_MULT * ((prod_r + {22'd0, k_r - 1'b1})
                    ^ ((prod_r + {22'd0, k_r - 1'b1}) >> 30));
          state_r <= S_SEED_WR;
        end
        S_TW_PRE: begin
          // fetch word 0 so its top bit is known for the first step
          state_r <= S_TW_RD;
        end
        S_TW_RD: begin
          if (!y0_ok_r) begin
            y0_r    <= da;
            y0_ok_r <= 1'b1;
          end
          state_r <= S_TW_WR;
        end
        S_TW_WR: begin
          // word k_r+1 read now is next pass's table[k]
          y0_r    <= da;
          y0_ok_r <= 1'b1;
          if (k_r == IDX_W'(STATE_WORDS - 1)) begin
            twisted_r <= 1'b1;
            ridx_r    <= '0;
            state_r   <= S_IDLE;
          end else begin
            k_r <= k_next;
            state_r <= S_TW_RD;
          end
        end
        S_DRAW_CHK: begin
          // data for ridx_r is on port a
          ridx_r <= ridx_r + 1'b1;
          if (cmd.kind == KIND_RAW || bv <= cmd.limit) begin
            out_r   <= (cmd.kind == KIND_RAW) ? tv : bv;
            ov_r    <= 1'b1;
            cmd_pop <= 1'b1;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `MTG_ASSERT_IMP(a_idx_range, 1'b1, ridx_r <= IDX_W'(STATE_WORDS), "read index past table")
  `MTG_ASSERT_NEXT(a_pop_single, cmd_pop, !cmd_pop, "command popped twice")
  `MTG_ASSERT_IMP(a_pop_valid, cmd_pop, cmd_valid, "pop from empty queue")
  `MTG_ASSERT_IMP(a_draw_ready, state_r == S_DRAW_CHK, twisted_r && seeded_r,
    "draw from untwisted table")
endmodule

[rtl/mersenne_twister_generator_top.sv]
// Top level of the MT19937 generator: front queue and table back end.
// Depends on mtg_pkg, mtg_if, mtg_front, mtg_back.
//
// Usage: items enter on in_ch (kind, limit) under valid/ready. Kind 0
// returns one tempered word on out_ch, kind 1 a value in 0..limit, kind 2
// reseeds from the seed register with no result, kind 3 is dropped.
// cfg_ch writes the seed register and is always ready.
// A draw from a ready table reads the table word into a register, then
// tempers and bound-checks it into the output register; the next item is
// picked up once the queue pops. A rejected bounded draw repeats the read
// and check. Every 624 words the table is twisted in place: word 0 is
// fetched first, then each word is read and then written. Seeding runs a
// multiply and then a write for each word, on restart and on the first draw
// after reset.
// Reset clears the queue, the output valid flag and the seeded flag and sets
// the seed to 5489; the table itself needs no clearing.
// A stalled receiver holds the output register; the two-entry input queue
// keeps accepting until full.
module mersenne_twister_generator_top (
  input logic       clk,
  input logic       rst_n,
  mtg_in_if.sink    in_ch,
  mtg_out_if.source out_ch,
  mtg_cfg_if.sink   cfg_ch
);
  import mtg_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  mtg_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop)
  );

  mtg_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .cmd_valid(cmd_valid),
    .cmd_pop(cmd_pop), .cfg_ch(cfg_ch), .out_ch(out_ch)
  );
endmodule
